[hdl/psa_pkg.sv]
// Shared widths, constants and the controller state type for the proportional
// share apportion block.
// No dependencies; compile first.
`default_nettype none

package psa_pkg;

  localparam int unsigned CAP_W = 32;   // capacity, share and total width
  localparam int unsigned SUM_W = 38;   // capacity sum and share sum width
  localparam int unsigned BIDX_W = 6;   // bucket index field width
  localparam int unsigned PROD_W = 2 * CAP_W;
  localparam int unsigned STEP_W = $clog2(CAP_W);

  // Controller states, one-hot
  typedef enum logic [9:0] {
    S_COLLECT = 10'b00_0000_0001,
    S_P_READ  = 10'b00_0000_0010,
    S_P_MUL   = 10'b00_0000_0100,
    S_P_LOAD  = 10'b00_0000_1000,
    S_P_DIV   = 10'b00_0001_0000,
    S_P_WRITE = 10'b00_0010_0000,
    S_REST    = 10'b00_0100_0000,
    S_E_READ  = 10'b00_1000_0000,
    S_E_LOAD  = 10'b01_0000_0000,
    S_E_WAIT  = 10'b10_0000_0000
  } psa_state_t;

endpackage

`default_nettype wire

[hdl/psa_if.sv]
// Valid/ready channel interfaces of the proportional share apportion block:
// bucket input words, share result words and the total configuration write.
// Depends on psa_pkg.
`default_nettype none

interface psa_in_if import psa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  logic             last;

  modport source (output valid, output capacity, output last, input ready);
  modport sink   (input valid, input capacity, input last, output ready);
endinterface

interface psa_out_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] bucket_index;
  logic [CAP_W-1:0]  share;
  logic              over_capacity;
  logic              zero_sum_error;
  logic              last_share;

  modport source (output valid, output bucket_index, output share, output over_capacity,
                  output zero_sum_error, output last_share, input ready);
  modport sink   (input valid, input bucket_index, input share, input over_capacity,
                  input zero_sum_error, input last_share, output ready);
endinterface

interface psa_cfg_if import psa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/proportional_share_apportion.sv]
// After the word marked last, each held bucket passes through a memory read, a 32x32
// multiply, a 32-step restoring divide by the capacity sum and a share write-back; then
// each result word is read, loaded and held until the sink takes it. One run is processed
// at a time; bucket words are taken one per cycle while collecting.
// Reset clears the total, the sum, the count and all control; the capacity and share
// memories are not cleared, only entries written in the current run are used.
`default_nettype none

module proportional_share_apportion import psa_pkg::*; #(
  parameter int unsigned MAX_BUCKETS_HELD = 64
) (
  input  wire         clk,
  input  wire         rst,
  psa_cfg_if.sink     cfg,
  psa_in_if.sink      bucket_in,
  psa_out_if.source   share_out
);

  localparam int unsigned AW = (MAX_BUCKETS_HELD > 1) ? $clog2(MAX_BUCKETS_HELD) : 1;
  localparam int unsigned CW = $clog2(MAX_BUCKETS_HELD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BUCKETS_HELD);

  // Control and run state
  psa_state_t        state;
  logic [CAP_W-1:0]  target_total;
  logic [SUM_W-1:0]  capacity_sum;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     idx;
  logic              zero_sum;
  logic [SUM_W-1:0]  share_sum;
  logic [CAP_W-1:0]  rest;

  // Datapath registers
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rem;
  logic [CAP_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  // Memories
  logic [CAP_W-1:0]  cap_mem   [MAX_BUCKETS_HELD];
  logic [CAP_W-1:0]  share_mem [MAX_BUCKETS_HELD];
  logic [CAP_W-1:0]  cap_rd;
  logic [CAP_W-1:0]  share_rd;
  logic [AW-1:0]     rd_addr;

  // Output register
  logic              out_valid;
  logic [BIDX_W-1:0] out_index;
  logic [CAP_W-1:0]  out_share;
  logic              out_over;
  logic              out_zero;
  logic              out_last;

  // Combinational helpers
  logic              in_fire;
  logic              out_fire;
  logic              can_store;
  logic [SUM_W-1:0]  capacity_sum_next;
  logic [CW-1:0]     entry_count_next;
  logic [SUM_W:0]    div_trial;
  logic [SUM_W:0]    div_diff;
  logic              div_bit;
  logic [SUM_W-1:0]  share_sum_next;
  logic [CAP_W-1:0]  share_val;
  logic              idx_is_last;

  assign in_fire   = bucket_in.valid && bucket_in.ready;
  assign out_fire  = share_out.valid && share_out.ready;
  assign can_store = (entry_count < MAX_CNT);

  assign bucket_in.ready = (state == S_COLLECT);
  assign cfg.ready       = 1'b1;

  assign share_out.valid          = out_valid;
  assign share_out.bucket_index   = out_index;
  assign share_out.share          = out_share;
  assign share_out.over_capacity  = out_over;
  assign share_out.zero_sum_error = out_zero;
  assign share_out.last_share     = out_last;

  // Accumulate the incoming word while the store has room
  always_comb begin
    capacity_sum_next = capacity_sum;
    entry_count_next  = entry_count;
    if (can_store) begin
      capacity_sum_next = capacity_sum + SUM_W'(bucket_in.capacity);
      entry_count_next  = entry_count + 1'b1;
    end
  end

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    div_trial = {rem, quo[CAP_W-1]};
    div_diff  = div_trial - {1'b0, capacity_sum};
    div_bit   = (div_trial >= {1'b0, capacity_sum});
  end

  assign share_sum_next = share_sum + SUM_W'(quo);
  assign idx_is_last    = (idx == entry_count - 1'b1);
  assign rd_addr        = idx[AW-1:0];

  // Final share: forced zero on a zero sum, else floor share plus one leftover unit for indices below rest
  always_comb begin
    if (zero_sum) begin
      share_val = '0;
    end else if (CAP_W'(idx) < rest) begin
      share_val = share_rd + 1'b1;
    end else begin
      share_val = share_rd;
    end
  end

  // Capacity memory: written while collecting, read in both passes
  always_ff @(posedge clk) begin
    if (in_fire && can_store) begin
      cap_mem[entry_count[AW-1:0]] <= bucket_in.capacity;
    end
    cap_rd <= cap_mem[rd_addr];
  end

  // Share memory: floor shares written in the divide pass, read in the emit pass
  always_ff @(posedge clk) begin
    if (state == S_P_WRITE) begin
      share_mem[rd_addr] <= quo;
    end
    share_rd <= share_mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_total <= '0;
    end else if (cfg.valid && cfg.ready) begin
      target_total <= cfg.data;
    end
  end

  // Datapath: multiply, then serial divide
  always_ff @(posedge clk) begin
    case (state)
      S_P_MUL: begin
        prod <= {{CAP_W{1'b0}}, target_total} * {{CAP_W{1'b0}}, cap_rd};
      end
      S_P_LOAD: begin
        // upper half is below the sum since capacity never exceeds the sum
        rem  <= SUM_W'(prod[PROD_W-1:CAP_W]);
        quo  <= prod[CAP_W-1:0];
        step <= '0;
      end
      S_P_DIV: begin
        rem  <= div_bit ? div_diff[SUM_W-1:0] : div_trial[SUM_W-1:0];
        quo  <= {quo[CAP_W-2:0], div_bit};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (state == S_E_LOAD) begin
      out_index <= BIDX_W'(idx);
      out_share <= share_val;
      out_over  <= (cap_rd < share_val);
      out_zero  <= zero_sum;
      out_last  <= idx_is_last;
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_COLLECT;
      capacity_sum <= '0;
      entry_count  <= '0;
      idx          <= '0;
      zero_sum     <= 1'b0;
      share_sum    <= '0;
      rest         <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (in_fire) begin
            capacity_sum <= capacity_sum_next;
            entry_count  <= entry_count_next;
            idx          <= '0;
            if (bucket_in.last) begin
              zero_sum  <= (capacity_sum_next == '0);
              share_sum <= '0;
              rest      <= '0;
              state     <= (capacity_sum_next == '0) ? S_E_READ : S_P_READ;
            end
          end
        end
        S_P_READ:  state <= S_P_MUL;
        S_P_MUL:   state <= S_P_LOAD;
        S_P_LOAD:  state <= S_P_DIV;
        S_P_DIV: begin
          if (step == STEP_W'(CAP_W - 1)) begin
            state <= S_P_WRITE;
          end
        end
        S_P_WRITE: begin
          share_sum <= share_sum_next;
          if (idx_is_last) begin
            idx   <= '0;
            state <= S_REST;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_P_READ;
          end
        end
        S_REST: begin
          // leftover units after flooring
          if (share_sum <= SUM_W'(target_total)) begin
            rest <= target_total - share_sum[CAP_W-1:0];
          end else begin
            rest <= '0;
          end
          state <= S_E_READ;
        end
        S_E_READ:  state <= S_E_LOAD;
        S_E_LOAD: begin
          out_valid <= 1'b1;
          state     <= S_E_WAIT;
        end
        S_E_WAIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            if (idx_is_last) begin
              capacity_sum <= '0;
              entry_count  <= '0;
              idx          <= '0;
              state        <= S_COLLECT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_E_READ;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // Checks
  a_count_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_COLLECT) |-> (entry_count != '0 && entry_count <= MAX_CNT))
    else $error("run in progress with an empty or overfull store");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    share_out.valid |-> (idx < entry_count))
    else $error("result word points past the held entries");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_DIV) |-> (rem < capacity_sum))
    else $error("partial remainder not below the capacity sum");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && share_out.last_share) |=> (state == S_COLLECT && entry_count == '0))
    else $error("run did not close after its final word");

endmodule

`default_nettype wire
